>>> sv/xscc_pkg.sv
package xscc_pkg;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_DECRYPT = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_KEY_X = 2'd0,
    CFG_KEY_Y = 2'd1,
    CFG_KEY_Z = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] SEED_X_MASK = 32'h09d4eceb;
  localparam logic [WORD_W-1:0] SEED_Y_MASK = 32'h7b1f5a0a;
  localparam logic [WORD_W-1:0] SEED_Z_MASK = 32'h5acb246e;
  localparam logic [WORD_W-1:0] CHECK_START = 32'hef561513;

  localparam logic [WORD_W-1:0] KEY_X_RESET = 32'd123456789;
  localparam logic [WORD_W-1:0] KEY_Y_RESET = 32'd362436069;
  localparam logic [WORD_W-1:0] KEY_Z_RESET = 32'd521288629;

  localparam logic [WORD_W-1:0] BYTE_MASK = 32'h000000ff;

  // Control from the datapath stage to the state holders
  typedef struct packed {
    logic restart;
    logic advance;
  } state_ctl_t;

endpackage

>>> sv/xscc_keystream.sv
module xscc_keystream (
  input  logic                      clk,
  input  logic                      rst_n,
  input  xscc_pkg::state_ctl_t      ctl,
  input  logic [xscc_pkg::WORD_W-1:0] key_x,
  input  logic [xscc_pkg::WORD_W-1:0] key_y,
  input  logic [xscc_pkg::WORD_W-1:0] key_z,
  output logic [xscc_pkg::WORD_W-1:0] ks_word
);

  logic [xscc_pkg::WORD_W-1:0] stream_x_r, stream_y_r, stream_z_r;
  logic [xscc_pkg::WORD_W-1:0] stream_x_nxt, stream_y_nxt, stream_z_nxt;
  logic [xscc_pkg::WORD_W-1:0] t0, t1, t2, t3;

  // xorshift mix of the oldest word
  always_comb begin
    t0 = stream_x_r;
    t1 = t0 ^ (t0 << 16);
    t2 = t1 ^ (t1 >> 5);
    t3 = t2 ^ (t2 << 1);
    ks_word = t3 ^ stream_y_r ^ stream_z_r;
  end

  always_comb begin
    stream_x_nxt = stream_x_r;
    stream_y_nxt = stream_y_r;
    stream_z_nxt = stream_z_r;
    if (ctl.restart) begin
      stream_x_nxt = xscc_pkg::SEED_X_MASK ^ key_z;
      stream_y_nxt = xscc_pkg::SEED_Y_MASK ^ key_x;
      stream_z_nxt = xscc_pkg::SEED_Z_MASK ^ key_y;
    end else if (ctl.advance) begin
      stream_x_nxt = stream_y_r;
      stream_y_nxt = stream_z_r;
      stream_z_nxt = ks_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_x_r <= xscc_pkg::KEY_X_RESET;
      stream_y_r <= xscc_pkg::KEY_Y_RESET;
      stream_z_r <= xscc_pkg::KEY_Z_RESET;
    end else begin
      stream_x_r <= stream_x_nxt;
      stream_y_r <= stream_y_nxt;
      stream_z_r <= stream_z_nxt;
    end
  end

endmodule

>>> sv/xscc_checksum.sv
module xscc_checksum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  xscc_pkg::state_ctl_t        ctl,
  input  logic [xscc_pkg::WORD_W-1:0] plain,
  output logic [xscc_pkg::WORD_W-1:0] check_cur,
  output logic [xscc_pkg::WORD_W-1:0] check_nxt
);

  logic [xscc_pkg::WORD_W-1:0] check_r;
  logic [xscc_pkg::WORD_W-1:0] c1, c2, c3;

  // Fold the plaintext into the checksum
  always_comb begin
    c1 = check_r ^ ((check_r - plain) << 16);
    c2 = c1 ^ ((c1 + plain) >> 5);
    c3 = c2 ^ (c2 << 1);
  end

  always_comb begin
    check_nxt = check_r;
    if (ctl.restart) begin
      check_nxt = xscc_pkg::CHECK_START;
    end else if (ctl.advance) begin
      check_nxt = c3;
    end
  end

  assign check_cur = check_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_r <= '0;
    end else begin
      check_r <= check_nxt;
    end
  end

endmodule

>>> sv/xorshift_stream_cipher_checksum_top.sv
// Stream cipher with running integrity checksum. Each transfer on the in_ side
// carries one operation (restart, encrypt or decrypt) and gives exactly one
// transfer on the out_ side with the transformed data and the checksum after
// the item. Restart reseeds the xorshift96 keystream from the three key
// registers and sets the checksum to its start value; key writes take effect
// at the next restart. Items move through an input register and a result
// register with the keystream step, data XOR and checksum fold in between, so
// the block takes one item per cycle while the result side is not stalled. An
// accepted item waits in the input register until the result register is free
// or draining; each item makes a single pass through the keystream and
// checksum update. Write the key registers only while idle.
module xorshift_stream_cipher_checksum_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [xscc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xscc_pkg::WORD_W-1:0]      cfg_data,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,  // data_in[31:0]
  input  logic [2:0]                       in_tuser,  // operation[1:0], byte_mode[2]
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [63:0]                      out_tdata  // data_out[31:0], checksum[63:32]
);

  // key registers
  logic [xscc_pkg::WORD_W-1:0] key_x_r, key_y_r, key_z_r;

  // input register stage
  logic                        s1_valid_r;
  xscc_pkg::op_t               s1_op_r;
  logic                        s1_byte_r;
  logic [xscc_pkg::WORD_W-1:0] s1_data_r;

  // result register stage
  logic                        out_valid_r;
  logic [xscc_pkg::WORD_W-1:0] out_data_r;
  logic [xscc_pkg::WORD_W-1:0] out_check_r;

  logic                        s1_move;
  logic                        in_xfer;
  logic [xscc_pkg::WORD_W-1:0] mask;
  logic [xscc_pkg::WORD_W-1:0] data_m;
  logic [xscc_pkg::WORD_W-1:0] ks_word;
  logic [xscc_pkg::WORD_W-1:0] check_cur;
  logic [xscc_pkg::WORD_W-1:0] check_nxt;
  logic [xscc_pkg::WORD_W-1:0] xor_res;
  logic [xscc_pkg::WORD_W-1:0] plain;
  logic [xscc_pkg::WORD_W-1:0] result;
  xscc_pkg::state_ctl_t        ctl;

  // Advance the input stage whenever the result register is free or draining
  assign s1_move   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_move;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_x_r <= xscc_pkg::KEY_X_RESET;
      key_y_r <= xscc_pkg::KEY_Y_RESET;
      key_z_r <= xscc_pkg::KEY_Z_RESET;
    end else if (cfg_we) begin
      case (xscc_pkg::cfg_idx_t'(cfg_index))
        xscc_pkg::CFG_KEY_X: key_x_r <= cfg_data;
        xscc_pkg::CFG_KEY_Y: key_y_r <= cfg_data;
        xscc_pkg::CFG_KEY_Z: key_z_r <= cfg_data;
        default: ;  // write beyond the register list: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Payload needs no reset; hold it while stalled
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r   <= xscc_pkg::op_t'(in_tuser[1:0]);
      s1_byte_r <= in_tuser[2];
      s1_data_r <= in_tdata;
    end
  end

  // State changes only when the held item moves into the result register
  always_comb begin
    ctl.restart = 1'b0;
    ctl.advance = 1'b0;
    if (s1_valid_r && s1_move) begin
      case (s1_op_r)
        xscc_pkg::OP_RESTART: ctl.restart = 1'b1;
        xscc_pkg::OP_ENCRYPT: ctl.advance = 1'b1;
        xscc_pkg::OP_DECRYPT: ctl.advance = 1'b1;
        default: ;
      endcase
    end
  end

  xscc_keystream u_keystream (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .key_x   (key_x_r),
    .key_y   (key_y_r),
    .key_z   (key_z_r),
    .ks_word (ks_word)
  );

  // Encrypt and decrypt share one XOR: data, new keystream word and the
  // checksum before the item. The plaintext for the fold is the input when
  // encrypting and the result when decrypting.
  always_comb begin
    mask    = s1_byte_r ? xscc_pkg::BYTE_MASK : '1;
    data_m  = s1_data_r & mask;
    xor_res = (data_m ^ ks_word ^ check_cur) & mask;
    plain   = (s1_op_r == xscc_pkg::OP_DECRYPT) ? xor_res : data_m;
    case (s1_op_r)
      xscc_pkg::OP_ENCRYPT: result = xor_res;
      xscc_pkg::OP_DECRYPT: result = xor_res;
      default:              result = '0;
    endcase
  end

  xscc_checksum u_checksum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .plain     (plain),
    .check_cur (check_cur),
    .check_nxt (check_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_move) begin
      out_data_r  <= result;
      out_check_r <= check_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_check_r, out_data_r};

endmodule

>>> sv/xscc_checker.sv
module xscc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // an accepted item is followed by a valid result at the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("accepted item did not reach the output");

  // an empty output side never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // reset empties the result side
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind xorshift_stream_cipher_checksum_top xscc_checker u_xscc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
